[rtl/sme_pkg.sv]
// Package for the stack machine executor: opcodes, status codes and word types.
// No dependencies.
package sme_pkg;

   localparam int StackDepth = 256;
   localparam int SpBits     = 9;
   localparam int AddrBits   = 8;
   localparam int IpBits     = 16;

   typedef enum logic [3:0] {
      OP_NOP  = 4'd0,
      OP_PUSH = 4'd1,
      OP_DUP  = 4'd2,
      OP_ADD  = 4'd3,
      OP_SUB  = 4'd4,
      OP_MUL  = 4'd5,
      OP_DIV  = 4'd6,
      OP_EQ   = 4'd7,
      OP_JMP  = 4'd8,
      OP_JZ   = 4'd9,
      OP_JNZ  = 4'd10,
      OP_HALT = 4'd11
   } opcode_type;

   typedef enum logic [2:0] {
      ST_OK      = 3'd0,
      ST_UNDER   = 3'd1,
      ST_OVER    = 3'd2,
      ST_ILLEGAL = 3'd3,
      ST_DIVZERO = 3'd4
   } status_type;

   typedef struct packed {
      logic [3:0]         req_type;
      logic signed [63:0] operand;
   } req_word_type;

   typedef struct packed {
      logic [2:0]         status;
      logic [15:0]        next_ip;
      logic               halted_flag;
      logic [8:0]         stack_depth;
      logic signed [63:0] top_value;
   } rsp_word_type;

endpackage

[rtl/stack_machine_executor_core.sv]
// Stack machine executor top level: stack memory, sequencer and shared ALU.
// Depends on sme_pkg.
//
// One instruction word is taken at a time; req_ready is low until its response
// word has been handed off. After the accept edge, every instruction passes through
// the stack-read states S_RD1 and S_RD2, using the single memory read port, then
// the execute and write-back state S_EXEC. The response word is then valid, and
// the block is ready again in the cycle after it has been taken. Mul adds the
// state S_MUL, which sums three 32x32 partial products, and div adds S_DIV, a
// one-bit-per-cycle restoring divider. The top-of-stack value is kept in a
// register so the response needs no extra read. No clearing pass is needed.
module stack_machine_executor_core (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  sme_pkg::req_word_type req_word,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output sme_pkg::rsp_word_type rsp_word
);
   import sme_pkg::*;

   typedef enum logic [6:0] {
      S_IDLE = 7'b0000001,
      S_RD1  = 7'b0000010,
      S_RD2  = 7'b0000100,
      S_MUL  = 7'b0001000,
      S_DIV  = 7'b0010000,
      S_EXEC = 7'b0100000,
      S_RSP  = 7'b1000000
   } state_type;

   state_type          state_ff, state_in;
   logic [63:0]        mem [StackDepth];
   logic [63:0]        rdata_ff;
   logic [3:0]         op_ff;
   logic [63:0]        opd_ff;
   logic [SpBits-1:0]  sp_ff;
   logic [IpBits-1:0]  ip_ff;
   logic               halt_ff;
   logic [63:0]        top_ff;
   logic [63:0]        sec_ff;
   logic [63:0]        acc_ff, acc_in;
   logic [63:0]        rem_ff, rem_in;
   logic [6:0]         cnt_ff, cnt_in;
   logic [2:0]         status_ff;
   logic               rsp_valid_ff;
   logic               mem_we;
   logic [AddrBits-1:0] mem_waddr;
   logic [AddrBits-1:0] mem_raddr;
   logic [63:0]        mem_wdata;
   logic               ok_in;
   logic [2:0]         stat_in;
   logic [63:0]        mag_t, mag_s;
   logic [64:0]        trial;
   logic [31:0]        mul_a, mul_b;
   logic [63:0]        mul_p;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word.status      = status_ff;
   assign rsp_word.next_ip     = ip_ff;
   assign rsp_word.halted_flag = halt_ff;
   assign rsp_word.stack_depth = sp_ff;
   assign rsp_word.top_value   = (sp_ff == '0) ? 64'sd0 : top_ff;

   // Stack memory with a registered read port.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rdata_ff <= mem[mem_raddr];
   end

   // Read address: the top entry while idle, then the second entry, or the
   // dup source entry for a dup.
   always_comb begin
      mem_raddr = sp_ff[AddrBits-1:0] - 8'd1;
      if (state_ff == S_RD1) begin
         if (op_ff == OP_DUP) begin
            mem_raddr = sp_ff[AddrBits-1:0] - 8'd1 - opd_ff[AddrBits-1:0];
         end else begin
            mem_raddr = sp_ff[AddrBits-1:0] - 8'd2;
         end
      end
   end

   // Magnitudes for the divider.
   assign mag_t = top_ff[63] ? (64'd0 - top_ff) : top_ff;
   assign mag_s = sec_ff[63] ? (64'd0 - sec_ff) : sec_ff;
   assign trial = {rem_ff, acc_ff[63]} - {1'b0, mag_s};

   // One 32x32 partial product per cycle, low 64 bits of the product kept.
   always_comb begin
      mul_a = top_ff[31:0];
      mul_b = sec_ff[31:0];
      case (cnt_ff[1:0])
         2'd1: begin mul_a = top_ff[63:32]; mul_b = sec_ff[31:0]; end
         2'd2: begin mul_a = top_ff[31:0];  mul_b = sec_ff[63:32]; end
         default: begin mul_a = top_ff[31:0]; mul_b = sec_ff[31:0]; end
      endcase
      mul_p = {32'd0, mul_a} * {32'd0, mul_b};
   end

   // Sequencer and datapath.
   always_comb begin
      state_in  = state_ff;
      acc_in    = acc_ff;
      rem_in    = rem_ff;
      cnt_in    = cnt_ff;
      mem_we    = 1'b0;
      mem_waddr = sp_ff[AddrBits-1:0];
      mem_wdata = opd_ff;
      ok_in     = 1'b0;
      stat_in   = ST_OK;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = S_RD1;
            end
         end
         S_RD1: begin
            state_in = S_RD2;
         end
         S_RD2: begin
            cnt_in = '0;
            acc_in = '0;
            rem_in = '0;
            if (op_ff == OP_MUL && sp_ff >= 9'd2) begin
               state_in = S_MUL;
            end else if (op_ff == OP_DIV && sp_ff >= 9'd2 && rdata_ff != 64'd0) begin
               acc_in   = mag_t;
               state_in = S_DIV;
            end else begin
               state_in = S_EXEC;
            end
         end
         S_MUL: begin
            cnt_in = cnt_ff + 7'd1;
            if (cnt_ff[1:0] == 2'd0) begin
               acc_in = mul_p;
            end else begin
               acc_in = acc_ff + {mul_p[31:0], 32'd0};
            end
            if (cnt_ff[1:0] == 2'd2) begin
               state_in = S_EXEC;
            end
         end
         S_DIV: begin
            cnt_in = cnt_ff + 7'd1;
            if (!trial[64]) begin
               rem_in = trial[63:0];
               acc_in = {acc_ff[62:0], 1'b1};
            end else begin
               rem_in = {rem_ff[62:0], acc_ff[63]};
               acc_in = {acc_ff[62:0], 1'b0};
            end
            if (cnt_ff == 7'd63) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            state_in = S_RSP;
            ok_in    = 1'b1;
            case (op_ff)
               OP_NOP, OP_JMP, OP_HALT: ;
               OP_PUSH: begin
                  if (sp_ff >= 9'(StackDepth)) begin
                     stat_in = ST_OVER;
                  end else begin
                     mem_we = 1'b1;
                  end
               end
               OP_DUP: begin
                  if (opd_ff[63] || opd_ff >= {55'd0, sp_ff}) begin
                     stat_in = ST_UNDER;
                  end else if (sp_ff >= 9'(StackDepth)) begin
                     stat_in = ST_OVER;
                  end else begin
                     mem_we    = 1'b1;
                     mem_wdata = sec_ff;
                  end
               end
               OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_EQ: begin
                  if (sp_ff < 9'd2) begin
                     stat_in = ST_UNDER;
                  end else if (op_ff == OP_DIV && sec_ff == 64'd0) begin
                     stat_in = ST_DIVZERO;
                  end else begin
                     mem_we    = 1'b1;
                     mem_waddr = sp_ff[AddrBits-1:0] - 8'd2;
                     case (op_ff)
                        OP_ADD:  mem_wdata = top_ff + sec_ff;
                        OP_SUB:  mem_wdata = top_ff - sec_ff;
                        OP_MUL:  mem_wdata = acc_ff;
                        OP_DIV:  mem_wdata = (top_ff[63] != sec_ff[63]) ?
                                             (64'd0 - acc_ff) : acc_ff;
                        default: mem_wdata = {63'd0, top_ff == sec_ff};
                     endcase
                  end
               end
               OP_JZ, OP_JNZ: begin
                  if (sp_ff == '0) begin
                     stat_in = ST_UNDER;
                  end
               end
               default: stat_in = ST_ILLEGAL;
            endcase
         end
         S_RSP: begin
            if (rsp_ready) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Control and architectural state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         sp_ff        <= '0;
         ip_ff        <= '0;
         halt_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == S_RSP && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (ok_in) begin
            rsp_valid_ff <= 1'b1;
            if (stat_in == ST_OK) begin
               case (op_ff)
                  OP_PUSH, OP_DUP: begin
                     sp_ff <= sp_ff + 9'd1;
                     ip_ff <= ip_ff + 16'd1;
                  end
                  OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_EQ: begin
                     sp_ff <= sp_ff - 9'd1;
                     ip_ff <= ip_ff + 16'd1;
                  end
                  OP_JMP: ip_ff <= ip_ff + opd_ff[IpBits-1:0];
                  OP_JZ, OP_JNZ: begin
                     sp_ff <= sp_ff - 9'd1;
                     if ((op_ff == OP_JZ) == (top_ff == 64'd0)) begin
                        ip_ff <= ip_ff + opd_ff[IpBits-1:0];
                     end else begin
                        ip_ff <= ip_ff + 16'd1;
                     end
                  end
                  OP_HALT: begin
                     halt_ff <= 1'b1;
                     ip_ff   <= ip_ff + 16'd1;
                  end
                  default: ip_ff <= ip_ff + 16'd1;
               endcase
            end
         end
      end
   end

   // Payload registers; top_ff tracks the entry at sp-1.
   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      rem_ff <= rem_in;
      cnt_ff <= cnt_in;
      if (state_ff == S_IDLE && req_valid) begin
         op_ff  <= req_word.req_type;
         opd_ff <= req_word.operand;
      end
      if (state_ff == S_RD1) begin
         top_ff <= rdata_ff;
      end
      if (state_ff == S_RD2) begin
         sec_ff <= rdata_ff;
      end
      if (ok_in) begin
         status_ff <= stat_in;
         if (mem_we) begin
            top_ff <= mem_wdata;
         end else if (stat_in == ST_OK && (op_ff == OP_JZ || op_ff == OP_JNZ)) begin
            top_ff <= sec_ff;
         end
      end
   end

endmodule

[tb/sv/tb_stack_machine_executor_core.sv]
// Testbench for stack_machine_executor_core: directed table, overflow fill, then random words,
// all checked against a behavioral stack machine predictor. Depends on sme_pkg and the core.
`timescale 1ns / 1ps

module tb_stack_machine_executor_core;
   import sme_pkg::*;

   localparam int NumRandom = 1420;

   logic         clock;
   logic         reset;
   logic         req_valid;
   logic         req_ready;
   req_word_type req_word;
   logic         rsp_valid;
   logic         rsp_ready;
   rsp_word_type rsp_word;

   stack_machine_executor_core u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word)
   );

   // Predictor state mirrors the machine state.
   logic [63:0]       model_stack [StackDepth];
   int unsigned       model_sp;
   logic [IpBits-1:0] model_ip;
   logic              model_halted;

   rsp_word_type expected_words[$];
   int           error_count;
   bit           stimulus_done;
   bit           hold_off_request;

   // Directed row: instruction, and an optional typed-in expectation.
   typedef struct {
      logic [3:0]   op;
      logic [63:0]  opd;
      bit           has_fixed;
      rsp_word_type fixed;
   } directed_row_type;

   directed_row_type directed_rows[$];

   initial clock = 1'b0;
   always #5 clock = ~clock;

   function automatic logic [63:0] signed_quotient(logic [63:0] a, logic [63:0] b);
      logic [63:0] ma;
      logic [63:0] mb;
      logic [63:0] q;
      ma = a[63] ? -a : a;
      mb = b[63] ? -b : b;
      q  = ma / mb;
      return (a[63] != b[63]) ? -q : q;
   endfunction

   // Execute one instruction on the predictor and return the response word.
   function automatic rsp_word_type execute_instruction(logic [3:0] op, logic [63:0] opd);
      status_type   st;
      logic [63:0]  t;
      logic [63:0]  s;
      logic [63:0]  r;
      rsp_word_type w;
      st = ST_OK;
      case (op)
         OP_NOP: model_ip = model_ip + 1;
         OP_PUSH: begin
            if (model_sp >= StackDepth) st = ST_OVER;
            else begin
               model_stack[model_sp] = opd;
               model_sp++;
               model_ip = model_ip + 1;
            end
         end
         OP_DUP: begin
            if (opd[63] || opd >= 64'(model_sp)) st = ST_UNDER;
            else if (model_sp >= StackDepth) st = ST_OVER;
            else begin
               model_stack[model_sp] = model_stack[model_sp - 1 - int'(opd)];
               model_sp++;
               model_ip = model_ip + 1;
            end
         end
         OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_EQ: begin
            if (model_sp < 2) st = ST_UNDER;
            else begin
               t = model_stack[model_sp - 1];
               s = model_stack[model_sp - 2];
               r = '0;
               case (op)
                  OP_ADD: r = t + s;
                  OP_SUB: r = t - s;
                  OP_MUL: r = t * s;
                  OP_DIV: if (s == 0) st = ST_DIVZERO; else r = signed_quotient(t, s);
                  default: r = (t == s) ? 64'd1 : 64'd0;
               endcase
               if (st == ST_OK) begin
                  model_stack[model_sp - 2] = r;
                  model_sp--;
                  model_ip = model_ip + 1;
               end
            end
         end
         OP_JMP: model_ip = model_ip + opd[IpBits-1:0];
         OP_JZ, OP_JNZ: begin
            if (model_sp == 0) st = ST_UNDER;
            else begin
               model_sp--;
               if ((op == OP_JZ) == (model_stack[model_sp] == 0))
                  model_ip = model_ip + opd[IpBits-1:0];
               else
                  model_ip = model_ip + 1;
            end
         end
         OP_HALT: begin
            model_halted = 1'b1;
            model_ip = model_ip + 1;
         end
         default: st = ST_ILLEGAL;
      endcase
      w.status      = st;
      w.next_ip     = model_ip;
      w.halted_flag = model_halted;
      w.stack_depth = model_sp[8:0];
      w.top_value   = (model_sp > 0) ? model_stack[model_sp - 1] : 64'd0;
      return w;
   endfunction

   // Offer one instruction word; valid stays high until the handshake.
   task automatic send_instruction(logic [3:0] op, logic [63:0] opd, bit has_fixed,
                                   rsp_word_type fixed);
      rsp_word_type w;
      req_word.req_type = op;
      req_word.operand  = opd;
      req_valid = 1'b1;
      do @(posedge clock); while (!req_ready);
      w = execute_instruction(op, opd);
      if (has_fixed && w != fixed) begin
         $display("%0t: directed row disagrees with predictor: expected %h actual %h",
                  $time, fixed, w);
         error_count++;
      end
      expected_words.push_back(w);
      @(negedge clock);
      req_valid = 1'b0;
   endtask

   function automatic directed_row_type make_row(logic [3:0] op, logic [63:0] opd);
      directed_row_type row;
      row.op = op;
      row.opd = opd;
      row.has_fixed = 1'b0;
      row.fixed = '0;
      return row;
   endfunction

   function automatic directed_row_type fixed_row(logic [3:0] op, logic [63:0] opd,
                                                  status_type st, logic [15:0] ip,
                                                  logic [8:0] depth, logic [63:0] top);
      directed_row_type row;
      row = make_row(op, opd);
      row.has_fixed = 1'b1;
      row.fixed.status = st;
      row.fixed.next_ip = ip;
      row.fixed.halted_flag = 1'b0;
      row.fixed.stack_depth = depth;
      row.fixed.top_value = top;
      return row;
   endfunction

   // Pick a random operand, biased toward small and extreme values.
   function automatic logic [63:0] random_operand();
      case ($urandom_range(0, 5))
         0: return {$urandom, $urandom};
         1: return 64'h8000_0000_0000_0000;
         2: return 64'($urandom_range(0, 3)) - 64'd1;
         3: return 64'h7fff_ffff_ffff_ffff;
         default: return 64'($urandom_range(0, 12));
      endcase
   endfunction

   // Main stimulus: directed table, stack overflow fill, then random bursts with gaps.
   initial begin
      directed_row_type row;
      logic [3:0]       op;
      int               pick;
      int               gap;
      req_valid = 1'b0;
      req_word = '0;
      reset = 1'b1;
      error_count = 0;
      stimulus_done = 1'b0;
      hold_off_request = 1'b0;
      model_sp = 0;
      model_ip = '0;
      model_halted = 1'b0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Empty-stack errors first, then extremes, division corners and halt.
      directed_rows.push_back(fixed_row(OP_ADD, 64'd0, ST_UNDER, 16'd0, 9'd0, 64'd0));
      directed_rows.push_back(fixed_row(OP_JZ, 64'd5, ST_UNDER, 16'd0, 9'd0, 64'd0));
      directed_rows.push_back(fixed_row(OP_DUP, 64'd0, ST_UNDER, 16'd0, 9'd0, 64'd0));
      directed_rows.push_back(fixed_row(4'd12, 64'd0, ST_ILLEGAL, 16'd0, 9'd0, 64'd0));
      directed_rows.push_back(fixed_row(4'd15, '1, ST_ILLEGAL, 16'd0, 9'd0, 64'd0));
      directed_rows.push_back(fixed_row(OP_PUSH, 64'hffff_ffff_ffff_ffff, ST_OK, 16'd1,
                                        9'd1, 64'hffff_ffff_ffff_ffff));
      directed_rows.push_back(fixed_row(OP_PUSH, 64'h8000_0000_0000_0000, ST_OK, 16'd2,
                                        9'd2, 64'h8000_0000_0000_0000));
      directed_rows.push_back(make_row(OP_DIV, 64'd0));        // minimum over minus one
      directed_rows.push_back(make_row(OP_PUSH, 64'd0));
      directed_rows.push_back(make_row(OP_DUP, 64'd1));
      directed_rows.push_back(make_row(OP_DIV, 64'd0));        // divide by zero
      directed_rows.push_back(make_row(OP_DUP, 64'hffff_ffff_ffff_ffff));
      directed_rows.push_back(make_row(OP_DUP, 64'd3));
      directed_rows.push_back(make_row(OP_PUSH, 64'h7fff_ffff_ffff_ffff));
      directed_rows.push_back(make_row(OP_PUSH, -64'sd7));
      directed_rows.push_back(make_row(OP_DIV, 64'd0));        // truncation toward zero
      directed_rows.push_back(make_row(OP_MUL, 64'd0));
      directed_rows.push_back(make_row(OP_SUB, 64'd0));
      directed_rows.push_back(make_row(OP_EQ, 64'd0));
      directed_rows.push_back(make_row(OP_JNZ, 64'hffff_ffff_ffff_fffe));
      directed_rows.push_back(make_row(OP_JZ, 64'd100));
      directed_rows.push_back(make_row(OP_JMP, 64'h8000_0000_0000_8000));
      directed_rows.push_back(make_row(OP_NOP, 64'd0));
      directed_rows.push_back(make_row(OP_HALT, 64'd0));
      directed_rows.push_back(make_row(OP_PUSH, 64'd9));     // still runs while halted
      foreach (directed_rows[i]) begin
         row = directed_rows[i];
         send_instruction(row.op, row.opd, row.has_fixed, row.fixed);
      end

      // Fill the stack to overflow with the receiver held off for a while.
      hold_off_request = 1'b1;
      while (model_sp < StackDepth) send_instruction(OP_PUSH, {$urandom, $urandom}, 0, '0);
      send_instruction(OP_PUSH, 64'd1, 0, '0);
      send_instruction(OP_DUP, 64'd0, 0, '0);
      send_instruction(OP_DUP, 64'd255, 0, '0);
      send_instruction(OP_DUP, 64'd256, 0, '0);
      hold_off_request = 1'b0;

      // Random part: bursts of instructions separated by gaps.
      for (int n = 0; n < NumRandom; ) begin
         if ($urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 6);
            repeat (gap) @(negedge clock);
         end
         for (int b = $urandom_range(1, 12); b > 0 && n < NumRandom; b--) begin
            pick = $urandom_range(0, 99);
            // Keep the stack mid-range so arithmetic rarely underflows.
            if (pick < 25 || model_sp < 2) op = OP_PUSH;
            else if (pick < 35) op = OP_DUP;
            else if (pick < 80) op = 4'($urandom_range(OP_ADD, OP_EQ));
            else if (pick < 94) op = 4'($urandom_range(OP_NOP, OP_HALT));
            else op = 4'($urandom_range(0, 15));
            if (op == OP_DUP && $urandom_range(0, 1))
               send_instruction(op, 64'($urandom_range(0, model_sp)), 0, '0);
            else if (op == OP_PUSH && model_sp > 200 && $urandom_range(0, 1))
               send_instruction(OP_EQ, 64'd0, 0, '0);
            else
               send_instruction(op, random_operand(), 0, '0);
            n++;
         end
      end
      stimulus_done = 1'b1;
   end

   // Receiver stall pattern, with a long hold-off when requested.
   initial begin
      int hold;
      rsp_ready = 1'b0;
      @(negedge clock);
      while (!reset) @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (hold_off_request) begin
            rsp_ready = 1'b0;
            hold = 0;
            while (hold < 600) begin
               @(negedge clock);
               hold++;
            end
            rsp_ready = 1'b1;
            while (hold_off_request) @(negedge clock);
         end else begin
            case ($urandom_range(0, 3))
               0: rsp_ready = 1'b0;
               1: rsp_ready = ($urandom_range(0, 1) == 1);
               default: rsp_ready = 1'b1;
            endcase
            @(negedge clock);
         end
      end
   end

   // Compare every accepted response word with the oldest expectation.
   always @(posedge clock) begin
      rsp_word_type w;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_words.size() == 0) begin
            $display("%0t: unexpected response word: expected none actual %h", $time, rsp_word);
            error_count++;
         end else begin
            w = expected_words.pop_front();
            if (rsp_word.status != w.status) begin
               $display("%0t: status expected %0d actual %0d", $time, w.status, rsp_word.status);
               error_count++;
            end
            if (rsp_word.next_ip != w.next_ip) begin
               $display("%0t: next_ip expected %h actual %h", $time, w.next_ip, rsp_word.next_ip);
               error_count++;
            end
            if (rsp_word.halted_flag != w.halted_flag) begin
               $display("%0t: halted_flag expected %b actual %b", $time, w.halted_flag,
                        rsp_word.halted_flag);
               error_count++;
            end
            if (rsp_word.stack_depth != w.stack_depth) begin
               $display("%0t: stack_depth expected %0d actual %0d", $time, w.stack_depth,
                        rsp_word.stack_depth);
               error_count++;
            end
            if (rsp_word.top_value != w.top_value) begin
               $display("%0t: top_value expected %h actual %h", $time, w.top_value,
                        rsp_word.top_value);
               error_count++;
            end
         end
      end
   end

   // Drain and report.
   initial begin
      wait (stimulus_done);
      while (expected_words.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (error_count == 0 && expected_words.size() == 0)
         $display("tb_stack_machine_executor_core: clean");
      else
         $display("tb_stack_machine_executor_core: errors");
      $finish;
   end

   // Watchdog for a hung handshake.
   initial begin
      #5ms;
      $display("tb_stack_machine_executor_core: errors");
      $finish;
   end

endmodule
